// ----- hw/rtl/qfx_pkg.sv -----
// ----------------------------------------------------------------------------
// Q17.14 fixed-point ALU package
// Operation codes and transaction payload types.
// ----------------------------------------------------------------------------
package qfx_pkg;

    localparam int unsigned DataWidth = 32;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]                  mode;
        logic signed [DataWidth-1:0] operand_a;
        logic signed [DataWidth-1:0] operand_b;
    } t_req;

    typedef struct packed {
        logic signed [DataWidth-1:0] result;
        logic                        overflow;
    } t_rsp;

endpackage

// ----- hw/rtl/qfx_recip.sv -----
// ----------------------------------------------------------------------------
// Pipelined reciprocal divider
// Restoring division of 2^(2*FRAC) by a 32-bit magnitude, one quotient bit
// per stage, with side-band data carried along.
// ----------------------------------------------------------------------------
module qfx_recip #(
    parameter int unsigned FRAC  = 14,
    parameter int unsigned SIDEW = 68
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [31:0]        i_mag,
    input  logic [SIDEW-1:0]   i_side,
    output logic               o_valid,
    output logic [31:0]        o_quot,
    output logic [SIDEW-1:0]   o_side
);
    localparam int unsigned NBits = 2 * FRAC + 1;
    localparam int unsigned QW    = NBits;

    logic             r_v    [NBits+1];
    logic [32:0]      r_rem  [NBits+1];
    logic [QW-1:0]    r_q    [NBits+1];
    logic [31:0]      r_mag  [NBits+1];
    logic [SIDEW-1:0] r_side [NBits+1];

    always_comb begin
        r_v[0]    = i_valid;
        r_rem[0]  = '0;
        r_q[0]    = '0;
        r_mag[0]  = i_mag;
        r_side[0] = i_side;
    end

    for (genvar s = 0; s < NBits; s++) begin : g_stage
        logic        dividend_bit;
        logic [33:0] n_shift;
        logic [33:0] n_diff;
        assign dividend_bit = (s == 0) ? 1'b1 : 1'b0;
        assign n_shift = {r_rem[s], dividend_bit};
        assign n_diff  = n_shift - {2'b00, r_mag[s]};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else begin
                r_v[s+1] <= r_v[s];
            end
            r_mag[s+1]  <= r_mag[s];
            r_side[s+1] <= r_side[s];
            if (!n_diff[33]) begin
                r_rem[s+1] <= n_diff[32:0];
                r_q[s+1]   <= {r_q[s][QW-2:0], 1'b1};
            end else begin
                r_rem[s+1] <= n_shift[32:0];
                r_q[s+1]   <= {r_q[s][QW-2:0], 1'b0};
            end
        end
    end

    assign o_valid = r_v[NBits];
    assign o_side  = r_side[NBits];
    if (QW >= 32) begin : g_wide
        assign o_quot = r_q[NBits][31:0];
    end else begin : g_narrow
        assign o_quot = {{(32-QW){1'b0}}, r_q[NBits]};
    end

endmodule

// ----- hw/rtl/q14_fixed_point_alu.sv -----
// ----------------------------------------------------------------------------
// Q17.14 fixed-point ALU
// Add, subtract, multiply and divide on signed 32-bit fixed-point operands.
// Every operation passes through the reciprocal divider (one quotient bit per
// stage) and then through stages M1, M2 and M3, so all share one latency.
// One transaction is accepted every cycle and busy is always low.
// Reset clears the valid bits of all stages; results are not held off.
// ----------------------------------------------------------------------------
module q14_fixed_point_alu #(
    parameter int unsigned FRACTION_BITS = 14
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  qfx_pkg::t_req i_req,
    output logic          o_strobe,
    output qfx_pkg::t_rsp o_rsp
);
    import qfx_pkg::*;

    localparam int unsigned SideW = 2 + 32 + 1 + 1;

    logic [31:0] n_mag;
    logic        b_neg;
    logic        b_zero;
    logic [31:0] sum_word;
    logic        sum_ov;

    logic             d_valid;
    logic [31:0]      d_quot;
    logic [SideW-1:0] d_side;
    logic [1:0]       d_mode;
    logic [31:0]      d_a;
    logic [31:0]      d_b_or_sum;

    logic [31:0] n_simple;
    logic        n_simple_ov;

    // Sum/difference computed up front, carried in place of operand b.
    assign b_neg  = i_req.operand_b[31];
    assign b_zero = (i_req.operand_b == '0);
    assign n_mag  = b_neg ? (32'd0 - i_req.operand_b) : i_req.operand_b;

    always_comb begin
        sum_word = '0;
        sum_ov   = 1'b0;
        case (t_op'(i_req.mode))
            OP_ADD: begin
                sum_word = i_req.operand_a + i_req.operand_b;
                sum_ov   = (i_req.operand_a[31] == i_req.operand_b[31]) &&
                           (i_req.operand_a[31] != sum_word[31]);
            end
            OP_SUB: begin
                sum_word = i_req.operand_a - i_req.operand_b;
                sum_ov   = (i_req.operand_a[31] != i_req.operand_b[31]) &&
                           (i_req.operand_a[31] != sum_word[31]);
            end
            default: begin
                sum_word = i_req.operand_b;
                sum_ov   = b_zero;
            end
        endcase
    end

    qfx_recip #(.FRAC(FRACTION_BITS), .SIDEW(SideW + 32)) u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_mag   (b_zero ? 32'd1 : n_mag),
        .i_side  ({i_req.mode, i_req.operand_a, sum_ov, b_neg, sum_word}),
        .o_valid (d_valid),
        .o_quot  (d_quot),
        .o_side  ({d_side, d_b_or_sum})
    );

    assign d_mode = d_side[SideW-1 -: 2];
    assign d_a    = d_side[33:2];

    // Stage M1: register multiplier operands.
    logic        r1_v;
    logic [1:0]  r1_mode;
    logic [31:0] r1_a, r1_m, r1_simple;
    logic        r1_ov, r1_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= d_valid;
        end
        r1_mode   <= d_mode;
        r1_a      <= d_a;
        r1_m      <= (t_op'(d_mode) == OP_DIV) ? d_quot : d_b_or_sum;
        r1_simple <= d_b_or_sum;
        r1_ov     <= d_side[1];
        r1_neg    <= d_side[0];
    end

    // Stage M2: signed product.
    logic        r2_v;
    logic [1:0]  r2_mode;
    logic signed [63:0] r2_p;
    logic [31:0] r2_simple;
    logic        r2_ov, r2_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        r2_mode   <= r1_mode;
        r2_p      <= $signed(r1_a) * $signed(r1_m);
        r2_simple <= r1_simple;
        r2_ov     <= r1_ov;
        r2_neg    <= r1_neg;
    end

    // Stage M3: scale, overflow check, sign fix, select.
    logic signed [63:0] n_shifted;
    logic [32:0]        n_top;
    logic               n_mul_ov;
    logic [31:0]        n_mul;
    logic               r3_v;
    t_rsp               r3_rsp;

    assign n_shifted = r2_p >>> FRACTION_BITS;
    assign n_top     = n_shifted[63:31];
    assign n_mul_ov  = !((n_top == '0) || (n_top == '1));
    assign n_mul     = n_shifted[31:0];

    always_comb begin
        n_simple    = r2_simple;
        n_simple_ov = r2_ov;
        case (t_op'(r2_mode))
            OP_MUL: begin
                n_simple    = n_mul;
                n_simple_ov = n_mul_ov;
            end
            OP_DIV: begin
                if (r2_ov) begin
                    n_simple    = '0;
                    n_simple_ov = 1'b1;
                end else begin
                    n_simple    = r2_neg ? (32'd0 - n_mul) : n_mul;
                    n_simple_ov = n_mul_ov;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
        r3_rsp.result   <= n_simple;
        r3_rsp.overflow <= n_simple_ov;
    end

    assign busy     = 1'b0;
    assign o_strobe = r3_v;
    assign o_rsp    = r3_rsp;

    a_busy_low: assert property (@(posedge i_clk) busy == 1'b0)
        else $error("busy asserted");
    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r2_v |=> o_strobe)
        else $error("result lost in final stage");
    a_div_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r2_v && (t_op'(r2_mode) == OP_DIV) && r2_ov) |=>
        (o_rsp.overflow && (o_rsp.result == '0)))
        else $error("divide by zero not flagged");
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r2_v |=> !o_strobe)
        else $error("spurious result");

endmodule
